// ===== rtl/cle_pkg.sv =====
// cle_pkg: command codes, request struct and character constants for the line editor
// depends on nothing; used by cle_front, cle_back and the top level
`default_nettype none

package cle_pkg;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_GT    = 8'd62;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_DEL   = 8'd127;

	localparam logic DEST_ECHO = 1'b0;
	localparam logic DEST_CMD  = 1'b1;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_DONE = 1'b1;

	// work handed from the front to the back
	typedef enum logic [1:0] {
		OP_ECHO   = 2'd0,	// echo and store one character
		OP_ERASE  = 2'd1,	// backspace space backspace
		OP_NLP    = 2'd2,	// newline then prompt
		OP_SUBMIT = 2'd3	// newline then the stored line
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

	// newline followed by the prompt
	function automatic logic [7:0] nlp_char(input logic [2:0] step);
		logic [7:0] c;
		unique case (step)
			3'd0: c = CH_LF;
			3'd1: c = CH_CR;
			3'd2, 3'd3: c = CH_GT;
			default: c = CH_SPACE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cle_front.sv =====
// cle_front: classifies each request and keeps the mode and line length
// depends on cle_pkg
`default_nettype none

module cle_front #(
	parameter int LINE_CHARS = 32,
	parameter int IDX_W = $clog2(LINE_CHARS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic             action,
	input  wire logic [7:0]       rx_byte,
	output logic                  cmd_valid,
	output cle_pkg::cmd_t         cmd,
	output logic [IDX_W-1:0]      idx,
	output logic                  waiting,
	output logic [IDX_W-1:0]      count
);
	import cle_pkg::*;

	localparam logic [IDX_W-1:0] COUNT_MAX = IDX_W'(LINE_CHARS - 1);

	logic             waiting_q;
	logic [IDX_W-1:0] count_q;
	logic             waiting_d;
	logic [IDX_W-1:0] count_d;

	always_comb begin
		cmd_valid = 1'b0;
		cmd.op    = OP_NLP;
		cmd.ch    = rx_byte;
		idx       = count_q;
		waiting_d = waiting_q;
		count_d   = count_q;
		if (waiting_q) begin
			if (action == ACT_DONE) begin
				cmd_valid = 1'b1;
				cmd.op    = OP_NLP;
				waiting_d = 1'b0;
			end
		end else if (action == ACT_BYTE) begin
			priority if (rx_byte == CH_CR || rx_byte == CH_LF) begin
				cmd_valid = 1'b1;
				if (count_q != '0) begin
					cmd.op    = OP_SUBMIT;
					count_d   = '0;
					waiting_d = 1'b1;
				end else begin
					cmd.op = OP_NLP;
				end
			end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
				if (count_q != '0) begin
					cmd_valid = 1'b1;
					cmd.op    = OP_ERASE;
					count_d   = count_q - IDX_W'(1);
				end
			end else if (rx_byte >= CH_SPACE && rx_byte <= CH_TILDE) begin
				cmd_valid = 1'b1;
				cmd.op    = OP_ECHO;
				// a full line keeps overwriting its last slot
				if (count_q != COUNT_MAX)
					count_d = count_q + IDX_W'(1);
			end else begin
				cmd_valid = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			count_q   <= '0;
		end else if (accept) begin
			waiting_q <= waiting_d;
			count_q   <= count_d;
		end
	end

	assign waiting = waiting_q;
	assign count   = count_q;

endmodule

`default_nettype wire

// ===== rtl/cle_queue.sv =====
// cle_queue: two-entry queue of requests between front and back
// depends on nothing
`default_nettype none

module cle_queue #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              empty
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== rtl/cle_back.sv =====
// cle_back: carries out queued requests, holds the line memory and the result register
// depends on cle_pkg
`default_nettype none

module cle_back #(
	parameter int LINE_CHARS = 32,
	parameter int IDX_W = $clog2(LINE_CHARS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire cle_pkg::cmd_t    q_cmd,
	input  wire logic [IDX_W-1:0] q_idx,
	output logic                  q_pop,
	output logic                  busy,
	output logic                  empty,
	input  wire logic             pop,
	output logic                  dest,
	output logic [7:0]            out_char,
	output logic                  last
);
	import cle_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [7:0]       ch_q;
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       step_q;
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] ptr_d;
	logic [7:0]       mem [LINE_CHARS];
	logic [7:0]       rd_data_q;
	logic             out_valid_q;
	logic             dest_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             emit;
	logic             r_dest;
	logic [7:0]       r_char;
	logic             r_last;
	logic             r_is_char;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign busy  = (state_q == ST_RUN);
	assign emit  = (state_q == ST_RUN) && (!out_valid_q || pop);

	always_comb begin
		r_dest    = DEST_ECHO;
		r_char    = ch_q;
		r_last    = 1'b0;
		r_is_char = 1'b0;
		unique case (op_q)
			OP_ECHO: begin
				r_char = ch_q;
				r_last = 1'b1;
			end
			OP_ERASE: begin
				r_char = (step_q == 3'd1) ? CH_SPACE : CH_BS;
				r_last = (step_q == 3'd2);
			end
			OP_NLP: begin
				r_char = nlp_char(step_q);
				r_last = (step_q == 3'd4);
			end
			OP_SUBMIT: begin
				if (step_q < 3'd2) begin
					r_char = nlp_char(step_q);
				end else begin
					r_is_char = 1'b1;
					r_dest    = DEST_CMD;
					r_char    = rd_data_q;
					r_last    = (ptr_q == idx_q - IDX_W'(1));
				end
			end
			default: r_char = ch_q;
		endcase
	end

	// read address follows the pointer so rd_data_q always shows mem[ptr_q]
	always_comb begin
		ptr_d = ptr_q;
		if (q_pop)
			ptr_d = '0;
		else if (emit && r_is_char)
			ptr_d = ptr_q + IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= 3'd0;
			ptr_q       <= '0;
		end else begin
			ptr_q <= ptr_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_RUN;
						step_q  <= 3'd0;
					end
				end
				ST_RUN: begin
					if (emit) begin
						if (r_last)
							state_q <= ST_IDLE;
						if (!r_is_char)
							step_q <= step_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q  <= q_cmd.op;
			ch_q  <= q_cmd.ch;
			idx_q <= q_idx;
		end
		if (emit) begin
			dest_q <= r_dest;
			char_q <= r_char;
			last_q <= r_last;
		end
	end

	// line memory
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.op == OP_ECHO)
			mem[q_idx] <= q_cmd.ch;
		rd_data_q <= mem[ptr_d];
	end

	assign empty    = !out_valid_q;
	assign dest     = dest_q;
	assign out_char = char_q;
	assign last     = last_q;

endmodule

`default_nettype wire

// ===== rtl/console_line_editor_top.sv =====
// a popped request first loads the back's request registers, then the result register
// throughput: the back emits one result per cycle while the result register is empty or popped,
//   and loads the next request only once the last result of the one before has been emitted
// the two-entry request queue lets push go on while the back still drains results
// reset: arst_n clears mode, line length, queue and result register; line memory is not cleared
`default_nettype none

module console_line_editor_top #(
	parameter int LINE_CHARS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request side
	input  wire logic       push,
	output logic            full,
	input  wire logic       action,
	input  wire logic [7:0] rx_byte,
	// result side
	output logic            empty,
	input  wire logic       pop,
	output logic            dest,
	output logic [7:0]      out_char,
	output logic            last
);
	import cle_pkg::*;

	localparam int IDX_W = $clog2(LINE_CHARS);
	localparam int CMD_W = $bits(cmd_t);
	localparam int Q_W   = CMD_W + IDX_W;

	// front side signals
	logic             accept;
	logic             f_valid;
	cmd_t             f_cmd;
	logic [IDX_W-1:0] f_idx;
	logic             f_waiting;
	logic [IDX_W-1:0] f_count;

	// queue signals
	logic [Q_W-1:0]   q_wdata;
	logic [Q_W-1:0]   q_rdata;
	logic             q_empty;
	logic             q_pop;
	cmd_t             q_cmd;
	logic [IDX_W-1:0] q_idx;

	logic             b_busy;

	// a request is taken whenever the queue has room, even if it makes no result
	assign accept = push && !full;

	cle_front #(
		.LINE_CHARS(LINE_CHARS),
		.IDX_W(IDX_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (action),
		.rx_byte  (rx_byte),
		.cmd_valid(f_valid),
		.cmd      (f_cmd),
		.idx      (f_idx),
		.waiting  (f_waiting),
		.count    (f_count)
	);

	// index rides above the command in one queue word
	assign q_wdata = {f_idx, f_cmd};

	cle_queue #(
		.W(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && f_valid),
		.push_data(q_wdata),
		.full     (full),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.empty    (q_empty)
	);

	assign q_cmd = cmd_t'(q_rdata[CMD_W-1:0]);
	assign q_idx = q_rdata[Q_W-1:CMD_W];

	cle_back #(
		.LINE_CHARS(LINE_CHARS),
		.IDX_W(IDX_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (q_cmd),
		.q_idx   (q_idx),
		.q_pop   (q_pop),
		.busy    (b_busy),
		.empty   (empty),
		.pop     (pop),
		.dest    (dest),
		.out_char(out_char),
		.last    (last)
	);

`ifndef ASSERT_OFF
	// waiting for command completion means the line was handed over and cleared
	a_wait_clear: assert property (@(posedge clk) disable iff (!arst_n)
		f_waiting |-> (f_count == '0))
		else $error("line length not cleared while waiting");

	// the back takes a new request only once the previous one is finished
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !b_busy)
		else $error("request taken while back is busy");

	// command characters come from the line memory and are always printable
	a_cmd_print: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && dest == DEST_CMD) |-> (out_char >= CH_SPACE && out_char <= CH_TILDE))
		else $error("non-printable command character");
`endif

endmodule

`default_nettype wire
